// ===== hdl/cenum_pkg.sv =====
// Shared types and constants for the combination enumerator.
// Holds the controller states and the command and status words between
// controller and datapath. No dependencies.
`default_nettype none

package cenum_pkg;

  localparam int MAX_SUBSET_DEF = 16;
  localparam int MAX_SET_DEF    = 64;

  localparam int VAL_W  = 7;
  localparam int K_W    = 5;
  localparam int POS_W  = 4;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [VAL_W-1:0] TOTAL_RESET  = VAL_W'(4);
  localparam logic [K_W-1:0]   CHOSEN_RESET = K_W'(2);

  // register index is paddr[2]
  localparam logic REG_TOTAL_ITEMS  = 1'b0;
  localparam logic REG_CHOSEN_COUNT = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PIVOT,
    ST_EMIT,
    ST_EXHAUST
  } state_t;

  typedef struct packed {
    logic rd_pivot;
    logic start;
    logic clr_started;
    logic set_done;
    logic take_pivot;
    logic emit_load;
    logic exh_load;
    logic pos_clear;
    logic pos_inc;
  } cmd_t;

  typedef struct packed {
    logic cfg_ok;
    logic started;
    logic done;
    logic is_final;
    logic bump;
    logic run_full;
    logic out_free;
    logic last_pos;
  } status_t;

endpackage

`default_nettype wire

// ===== hdl/cenum_ctrl.sv =====
// Controller for the combination enumerator: request decode and the
// pivot / emit / exhausted sequence. Depends on cenum_pkg.
`default_nettype none

module cenum_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                req_valid,
  input  wire                restart,
  output logic               req_stall,
  input  cenum_pkg::status_t status,
  output cenum_pkg::cmd_t    cmd
);

  import cenum_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_stall  = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          if (!status.cfg_ok) begin
            cmd.clr_started = restart;
            state_next      = ST_EXHAUST;
          end else if (restart) begin
            cmd.start  = 1'b1;
            state_next = ST_EMIT;
          end else if (!status.started || status.done) begin
            state_next = ST_EXHAUST;
          end else if (status.is_final) begin
            cmd.set_done = 1'b1;
            state_next   = ST_EXHAUST;
          end else if (status.bump || !status.run_full) begin
            cmd.rd_pivot = 1'b1;
            state_next   = ST_PIVOT;
          end else begin
            cmd.set_done = 1'b1;
            state_next   = ST_EXHAUST;
          end
        end
      end
      ST_PIVOT: begin
        cmd.take_pivot = 1'b1;
        state_next     = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) begin
          cmd.emit_load = 1'b1;
          if (status.last_pos) begin
            cmd.pos_clear = 1'b1;
            state_next    = ST_IDLE;
          end else begin
            cmd.pos_inc = 1'b1;
          end
        end
      end
      ST_EXHAUST: begin
        if (status.out_free) begin
          cmd.exh_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/cenum_dpath.sv =====
// Datapath for the combination enumerator: config registers, member store,
// pivot and run registers, refill arithmetic and the output register.
// Depends on cenum_pkg.
`default_nettype none

module cenum_dpath #(
  parameter int MAX_SUBSET = cenum_pkg::MAX_SUBSET_DEF,
  parameter int MAX_SET    = cenum_pkg::MAX_SET_DEF
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire                                cfg_sel,
  input  wire  [cenum_pkg::DATA_W-1:0]       cfg_wdata,
  output logic [cenum_pkg::DATA_W-1:0]       cfg_rdata,
  input  wire                                cfg_rsel,
  input  cenum_pkg::cmd_t                    cmd,
  output cenum_pkg::status_t                 status,
  input  wire                                res_stall,
  output logic                               res_valid,
  output logic [cenum_pkg::VAL_W-1:0]        element_value,
  output logic [cenum_pkg::POS_W-1:0]        element_position,
  output logic                               last_element,
  output logic                               final_subset,
  output logic                               exhausted
);

  import cenum_pkg::*;

  localparam int IW = (MAX_SUBSET > 1) ? $clog2(MAX_SUBSET) : 1;

  logic [VAL_W-1:0] total_items;
  logic [K_W-1:0]   chosen_count;
  logic [VAL_W-1:0] pivot_value;
  logic [K_W-1:0]   run_length;
  logic             started;
  logic             done_flag;
  logic [VAL_W-1:0] first_member;
  logic [IW-1:0]    pos;
  logic [IW-1:0]    pos_next;
  logic [IW-1:0]    rd_addr;
  logic [VAL_W-1:0] rdata;

  logic [VAL_W-1:0] members [MAX_SUBSET];

  logic [7:0]       n_ext;
  logic [7:0]       k_ext;
  logic [7:0]       run_ext;
  logic [7:0]       lim;
  logic [K_W-1:0]   piv_idx;
  logic [K_W-1:0]   pos_ext;
  logic [K_W-1:0]   base;
  logic [K_W-1:0]   offset;
  logic             refill;
  logic [VAL_W-1:0] value;
  logic             val_final;

  // config port
  always_ff @(posedge clk) begin
    if (rst) begin
      total_items  <= TOTAL_RESET;
      chosen_count <= CHOSEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_sel)
        REG_TOTAL_ITEMS:  total_items  <= cfg_wdata[VAL_W-1:0];
        REG_CHOSEN_COUNT: chosen_count <= cfg_wdata[K_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_rsel)
      REG_TOTAL_ITEMS:  cfg_rdata = DATA_W'(total_items);
      REG_CHOSEN_COUNT: cfg_rdata = DATA_W'(chosen_count);
      default:          cfg_rdata = '0;
    endcase
  end

  // status
  assign n_ext   = {1'b0, total_items};
  assign k_ext   = 8'(chosen_count);
  assign run_ext = 8'(run_length);
  assign lim     = n_ext - k_ext + 8'd1;

  assign status.cfg_ok   = (chosen_count != '0) && (k_ext <= n_ext) &&
                           (k_ext <= 8'(MAX_SUBSET)) && (n_ext <= 8'(MAX_SET));
  assign status.started  = started;
  assign status.done     = done_flag;
  assign status.is_final = ({1'b0, first_member} == lim);
  assign status.bump     = (n_ext >= run_ext) ? ({1'b0, pivot_value} < (n_ext - run_ext))
                                              : 1'b1;
  assign status.run_full = (run_length >= chosen_count);
  assign status.out_free = !res_valid || !res_stall;
  assign status.last_pos = (pos_ext == chosen_count - K_W'(1));

  // member store, one read port with registered data
  assign piv_idx = status.bump ? (chosen_count - K_W'(1))
                               : (chosen_count - run_length - K_W'(1));

  always_comb begin
    if (cmd.pos_clear) begin
      pos_next = '0;
    end else if (cmd.pos_inc) begin
      pos_next = pos + IW'(1);
    end else begin
      pos_next = pos;
    end
  end

  assign rd_addr = cmd.rd_pivot ? piv_idx[IW-1:0] : pos_next;

  // tail refill: positions from k-run on take pivot+1, pivot+2, ...
  assign pos_ext   = K_W'(pos);
  assign base      = chosen_count - run_length;
  assign refill    = (pos_ext >= base);
  assign offset    = pos_ext - base;
  assign value     = refill ? (pivot_value + VAL_W'(offset) + VAL_W'(1)) : rdata;
  assign val_final = ({1'b0, value} == lim);

  always_ff @(posedge clk) begin
    rdata <= members[rd_addr];
    if (cmd.emit_load && refill) begin
      members[pos] <= value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

  // enumeration state
  always_ff @(posedge clk) begin
    if (rst) begin
      pivot_value  <= '0;
      run_length   <= '0;
      started      <= 1'b0;
      done_flag    <= 1'b0;
      first_member <= '0;
    end else begin
      if (cmd.start) begin
        pivot_value <= '0;
        run_length  <= chosen_count;
        started     <= 1'b1;
        done_flag   <= 1'b0;
      end
      if (cmd.clr_started) begin
        started <= 1'b0;
      end
      if (cmd.set_done) begin
        done_flag <= 1'b1;
      end
      if (cmd.take_pivot) begin
        pivot_value <= rdata;
        run_length  <= status.bump ? K_W'(1) : (run_length + K_W'(1));
      end
      if (cmd.emit_load && (pos == '0)) begin
        first_member <= value;
      end
      if (cfg_we) begin
        started   <= 1'b0;
        done_flag <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit_load || cmd.exh_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      element_value    <= value;
      element_position <= pos_ext[POS_W-1:0];
      last_element     <= status.last_pos;
      final_subset     <= (pos == '0) ? val_final : status.is_final;
      exhausted        <= 1'b0;
    end else if (cmd.exh_load) begin
      element_value    <= '0;
      element_position <= '0;
      last_element     <= 1'b1;
      final_subset     <= 1'b0;
      exhausted        <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/combination_enumerator.sv =====
// Top level of the combination enumerator: APB config port, controller and
// datapath. Depends on cenum_pkg, cenum_ctrl and cenum_dpath.
//
// Steps through the k-subsets of {1..n} in lexicographic order, one subset per
// request word. A restart word loads 1..k; an advance word moves to the next
// subset. Each subset leaves as k result words (one member each, position
// order), the last marked; a request with nothing to give returns one word
// marked exhausted. An advance passes through a pivot state, which reads the pivot
// from the member store's one read port, before the emit state; a restart goes
// straight to emit. The output register moves one member per cycle while the
// output is not stalled. Requests are taken one at a time.
// n and k may be written only while the block is idle; a write ends the
// current enumeration and a restart is needed.
`default_nettype none

module combination_enumerator #(
  parameter int MAX_SUBSET = cenum_pkg::MAX_SUBSET_DEF,
  parameter int MAX_SET    = cenum_pkg::MAX_SET_DEF
) (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           psel,
  input  wire                           penable,
  input  wire                           pwrite,
  input  wire  [cenum_pkg::ADDR_W-1:0]  paddr,
  input  wire  [cenum_pkg::DATA_W-1:0]  pwdata,
  output logic [cenum_pkg::DATA_W-1:0]  prdata,
  output logic                          pready,
  input  wire                           req_valid,
  output logic                          req_stall,
  input  wire                           restart,
  output logic                          res_valid,
  input  wire                           res_stall,
  output logic [cenum_pkg::VAL_W-1:0]   element_value,
  output logic [cenum_pkg::POS_W-1:0]   element_position,
  output logic                          last_element,
  output logic                          final_subset,
  output logic                          exhausted
);

  import cenum_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready;

  cenum_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .restart   (restart),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  cenum_dpath #(
    .MAX_SUBSET (MAX_SUBSET),
    .MAX_SET    (MAX_SET)
  ) u_dpath (
    .clk              (clk),
    .rst              (rst),
    .cfg_we           (cfg_we),
    .cfg_sel          (paddr[2]),
    .cfg_wdata        (pwdata),
    .cfg_rdata        (prdata),
    .cfg_rsel         (paddr[2]),
    .cmd              (cmd),
    .status           (status),
    .res_stall        (res_stall),
    .res_valid        (res_valid),
    .element_value    (element_value),
    .element_position (element_position),
    .last_element     (last_element),
    .final_subset     (final_subset),
    .exhausted        (exhausted)
  );

endmodule

`default_nettype wire

// ===== hdl/cenum_checker.sv =====
// Port-level checks for the combination enumerator, bound to the top level.
// Depends on cenum_pkg and combination_enumerator.
`default_nettype none

module cenum_checker (
  input wire                         clk,
  input wire                         rst,
  input wire                         req_valid,
  input wire                         req_stall,
  input wire                         res_valid,
  input wire                         res_stall,
  input wire [cenum_pkg::VAL_W-1:0]  element_value,
  input wire [cenum_pkg::POS_W-1:0]  element_position,
  input wire                         last_element,
  input wire                         final_subset,
  input wire                         exhausted
);

  // stalled result word holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(element_value) &&
      $stable(element_position) && $stable(last_element) && $stable(exhausted))
    else $error("result word changed under stall");

  // exhausted word has fixed shape
  a_exh_shape: assert property (@(posedge clk) disable iff (rst)
    res_valid && exhausted |-> last_element && !final_subset &&
      (element_value == '0) && (element_position == '0))
    else $error("malformed exhausted word");

  // members are 1-based
  a_member_nonzero: assert property (@(posedge clk) disable iff (rst)
    res_valid && !exhausted |-> (element_value != '0))
    else $error("zero member emitted");

  // one request at a time
  a_req_single: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second request taken while busy");

endmodule

bind combination_enumerator cenum_checker u_cenum_checker (.*);

`default_nettype wire

// ===== tb/combination_enumerator_test.sv =====
// Self-checking testbench for combination_enumerator: drives request words and
// APB register writes, predicts every result word and checks it on arrival.
// Depends on cenum_pkg and the combination_enumerator RTL.
module combination_enumerator_test;
  import cenum_pkg::*;

  localparam int SUBSET_CAP  = MAX_SUBSET_DEF;
  localparam int SET_CAP     = MAX_SET_DEF;
  localparam int QUIET_LIMIT = 5000;
  localparam int ITEM_TARGET = 250;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] pos;
    logic             last;
    logic             fin;
    logic             exh;
  } member_word_t;

  logic              clk = 1'b0;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              req_valid;
  logic              req_stall;
  logic              restart;
  logic              res_valid;
  logic              res_stall;
  logic [VAL_W-1:0]  element_value;
  logic [POS_W-1:0]  element_position;
  logic              last_element;
  logic              final_subset;
  logic              exhausted;

  // shadow of the enumerator
  logic [VAL_W-1:0] total_n;
  logic [K_W-1:0]   chosen_k;
  logic [VAL_W-1:0] cur_subset [SUBSET_CAP];
  int unsigned      pivot_val;
  int unsigned      tail_run;
  bit               enum_live;
  bit               enum_done;

  member_word_t words_due[$];
  int           errors;
  int           items_sent;
  int           hold_left;
  int           quiet_cycles;
  bit           calm;

  combination_enumerator i_dut (
    .clk              (clk),
    .rst              (rst),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .req_valid        (req_valid),
    .req_stall        (req_stall),
    .restart          (restart),
    .res_valid        (res_valid),
    .res_stall        (res_stall),
    .element_value    (element_value),
    .element_position (element_position),
    .last_element     (last_element),
    .final_subset     (final_subset),
    .exhausted        (exhausted)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void push_word(int value, int pos, bit last, bit fin, bit exh);
    member_word_t w;
    w.value = VAL_W'(value);
    w.pos   = POS_W'(pos);
    w.last  = last;
    w.fin   = fin;
    w.exh   = exh;
    words_due.push_back(w);
  endfunction

  function automatic void emit_current();
    int kk;
    bit fin;
    kk  = int'(chosen_k);
    fin = (int'(cur_subset[0]) == int'(total_n) - kk + 1);
    for (int i = 0; i < kk; i++) push_word(cur_subset[i], i, i == kk - 1, fin, 1'b0);
  endfunction

  function automatic void step_enumeration(bit rs);
    int unsigned kk;
    int unsigned nn;
    int unsigned idx;
    kk = chosen_k;
    nn = total_n;
    if (!(kk >= 1 && kk <= nn && kk <= SUBSET_CAP && nn <= SET_CAP)) begin
      if (rs) enum_live = 1'b0;
      push_word(0, 0, 1'b1, 1'b0, 1'b1);
      return;
    end
    if (rs) begin
      for (int unsigned i = 0; i < kk; i++) cur_subset[i] = VAL_W'(i + 1);
      pivot_val = 0;
      tail_run  = kk;
      enum_live = 1'b1;
      enum_done = 1'b0;
      emit_current();
      return;
    end
    if (!enum_live || enum_done || cur_subset[0] == nn - kk + 1) begin
      if (enum_live && !enum_done) enum_done = 1'b1;
      push_word(0, 0, 1'b1, 1'b0, 1'b1);
      return;
    end
    if (pivot_val < nn - tail_run) begin
      tail_run  = 1;
      pivot_val = cur_subset[kk-1];
    end else begin
      if (tail_run >= kk) begin
        enum_done = 1'b1;
        push_word(0, 0, 1'b1, 1'b0, 1'b1);
        return;
      end
      pivot_val = cur_subset[kk-tail_run-1];
      tail_run  = tail_run + 1;
    end
    for (int unsigned i = 1; i <= tail_run; i++) begin
      idx = kk - tail_run - 1 + i;
      if (idx < SUBSET_CAP) cur_subset[idx] = VAL_W'(pivot_val + i);
    end
    pivot_val = pivot_val & 32'h7f;
    tail_run  = tail_run & 32'h1f;
    emit_current();
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  // result side: check each accepted word, then draw the next stall
  always @(posedge clk) begin
    member_word_t w;
    if (rst) begin
      res_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (res_valid && !res_stall) begin
        if (words_due.size() == 0) begin
          $display("%0t: unexpected word, actual value %0d pos %0d exhausted %0b", $time,
                   element_value, element_position, exhausted);
          errors++;
        end else begin
          w = words_due.pop_front();
          check_field("element_value", w.value, element_value);
          check_field("element_position", w.pos, element_position);
          check_field("last_element", w.last, last_element);
          check_field("final_subset", w.fin, final_subset);
          check_field("exhausted", w.exh, exhausted);
        end
        hold_left = calm ? 0 : $urandom_range(0, 6);
      end else if (hold_left > 0) begin
        hold_left--;
      end
      res_stall <= (hold_left > 0);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall) ||
        (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(bit rs);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    restart   <= rs;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    step_enumeration(rs);
    items_sent++;
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    do @(posedge clk); while (words_due.size() != 0);
  endtask

  task automatic reg_access(bit wr, logic idx, logic [DATA_W-1:0] data);
    logic [DATA_W-1:0] held;
    wait_drained();
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (wr) begin
      if (idx == REG_TOTAL_ITEMS) total_n = data[VAL_W-1:0];
      else chosen_k = data[K_W-1:0];
      enum_live = 1'b0;
      enum_done = 1'b0;
    end else begin
      held = (idx == REG_TOTAL_ITEMS) ? DATA_W'(total_n) : DATA_W'(chosen_k);
      if (prdata !== held) begin
        $display("%0t: prdata mismatch at register %0d, expected %0d, actual %0d", $time,
                 idx, held, prdata);
        errors++;
      end
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(int n, int k);
    reg_access(1'b1, REG_TOTAL_ITEMS, n);
    reg_access(1'b1, REG_CHOSEN_COUNT, k);
  endtask

  task automatic test_default_walk();
    reg_access(1'b0, REG_TOTAL_ITEMS, '0);
    reg_access(1'b0, REG_CHOSEN_COUNT, '0);
    send_request(1'b0);
    send_request(1'b1);
    repeat (7) send_request(1'b0);
  endtask

  task automatic test_config_extremes();
    set_config(1, 1);
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    set_config(SET_CAP, SUBSET_CAP);
    send_request(1'b1);
    send_request(1'b0);
    send_request(1'b0);
    reg_access(1'b0, REG_TOTAL_ITEMS, '0);
    reg_access(1'b0, REG_CHOSEN_COUNT, '0);
    set_config(SUBSET_CAP, SUBSET_CAP);
    send_request(1'b1);
    send_request(1'b0);
    set_config(SUBSET_CAP, 0);
    send_request(1'b1);
    send_request(1'b0);
    set_config(3, 5);
    send_request(1'b1);
    set_config(SET_CAP, SUBSET_CAP + 1);
    send_request(1'b1);
    set_config(SET_CAP + 1, 2);
    send_request(1'b1);
    set_config(127, 31);
    send_request(1'b1);
    send_request(1'b0);
    reg_access(1'b0, REG_TOTAL_ITEMS, '0);
    reg_access(1'b0, REG_CHOSEN_COUNT, '0);
    set_config(0, 31);
    send_request(1'b1);
  endtask

  task automatic test_random_walks();
    int phase;
    int mode;
    int len;
    int n;
    int k;
    phase = 0;
    while (items_sent < ITEM_TARGET) begin
      mode = (phase == 0) ? 1 : $urandom_range(0, 9);
      calm = ($urandom_range(0, 3) == 0);
      len  = $urandom_range(10, 30);
      case (mode)
        0: begin
          n   = $urandom_range(0, 127);
          k   = $urandom_range(0, 31);
          len = $urandom_range(3, 8);
        end
        1: begin
          // single members walk all the way up to the top of the set
          n   = SET_CAP;
          k   = 1;
          len = SET_CAP + 3;
        end
        2, 3: begin
          n = $urandom_range(12, SET_CAP);
          k = $urandom_range(13, SUBSET_CAP);
          if (k > n) k = n;
        end
        default: begin
          n = $urandom_range(1, 10);
          k = $urandom_range(1, n);
        end
      endcase
      set_config(n, k);
      for (int i = 0; i < len; i++) begin
        if (i == len / 2 && (phase == 0 || $urandom_range(0, 3) == 0)) wait_drained();
        if (i == 0) send_request(mode == 1 || $urandom_range(0, 7) != 0);
        else send_request(mode != 1 && $urandom_range(0, 9) == 0);
      end
      phase++;
    end
    calm = 1'b0;
  endtask

  initial begin
    rst       <= 1'b1;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    req_valid <= 1'b0;
    restart   <= 1'b0;
    res_stall <= 1'b0;
    errors     = 0;
    items_sent = 0;
    calm       = 1'b0;
    total_n    = TOTAL_RESET;
    chosen_k   = CHOSEN_RESET;
    foreach (cur_subset[i]) cur_subset[i] = '0;
    pivot_val  = 0;
    tail_run   = 0;
    enum_live  = 1'b0;
    enum_done  = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_default_walk();
    test_config_extremes();
    test_random_walks();
    wait_drained();
    repeat (40) @(posedge clk);
    if (errors == 0 && words_due.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
